[src/q8d_pkg.sv]
// Shared constants and the half-scale times byte conversion function.
`default_nettype none
package q8d_pkg;
  localparam int BLOCK_ELEMENTS_DEF = 32;
  localparam int PROD_W = 18;

  function automatic logic [31:0] scale_value(input logic [15:0] h, input logic [7:0] q);
    logic hsign, qneg, sgn;
    logic [4:0] hexp;
    logic [9:0] hman;
    logic [7:0] qmag;
    logic [10:0] mfull;
    logic [4:0] e;
    logic [PROD_W-1:0] prod;
    logic [4:0] top;
    logic [PROD_W-1:0] norm;
    logic [7:0] fexp;
    hsign = h[15];
    hexp = h[14:10];
    hman = h[9:0];
    qneg = q[7];
    qmag = qneg ? (8'd0 - q) : q;
    sgn = hsign ^ qneg;
    mfull = (hexp == 5'd0) ? {1'b0, hman} : {1'b1, hman};
    e = (hexp == 5'd0) ? 5'd1 : hexp;
    prod = PROD_W'(mfull * qmag);
    top = 5'd0;
    for (int i = 0; i < PROD_W; i++) begin
      if (prod[i]) top = 5'(i);
    end
    norm = prod << (5'(PROD_W - 1) - top);
    fexp = 8'(top) + 8'(e) + 8'd102;
    if (hexp == 5'd31) begin
      if (hman != 10'd0) scale_value = {hsign, 8'hFF, 1'b1, hman[8:0], 13'd0};
      else if (qmag == 8'd0) scale_value = 32'hFFC00000;
      else scale_value = {sgn, 31'h7F800000};
    end else if (prod == '0) begin
      scale_value = {sgn, 31'd0};
    end else begin
      scale_value = {sgn, fexp, norm[PROD_W-2:0], 6'd0};
    end
  endfunction
endpackage
`default_nettype wire

[src/q8d_ctrl.sv]
// Byte position tracking and scale capture.
`default_nettype none
module q8d_ctrl import q8d_pkg::*; #(
  parameter int BLOCK_ELEMENTS = BLOCK_ELEMENTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        take,
  input  wire logic [7:0]  byte_in,
  output logic             is_elem,
  output logic             is_last,
  output logic [15:0]      scale
);
  localparam int PW = $clog2(BLOCK_ELEMENTS + 2);
  logic [PW-1:0] pos_r, pos_nxt;
  logic [15:0] scale_r, scale_nxt;
  always_comb begin
    pos_nxt = pos_r;
    scale_nxt = scale_r;
    if (take) begin
      if (pos_r == PW'(0)) scale_nxt[7:0] = byte_in;
      if (pos_r == PW'(1)) scale_nxt[15:8] = byte_in;
      pos_nxt = is_last ? PW'(0) : pos_r + PW'(1);
    end
  end
  assign is_elem = pos_r >= PW'(2);
  assign is_last = pos_r == PW'(BLOCK_ELEMENTS + 1);
  assign scale = scale_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      scale_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      scale_r <= scale_nxt;
    end
  end
endmodule
`default_nettype wire

[src/q8_0_block_dequantizer_unit.sv]
// Top level of the Q8_0 block dequantizer.
// Usage:
//   in_valid/in_ready carry one stream byte per request. Each block is two
//   scale bytes (half precision, low byte first) then BLOCK_ELEMENTS signed
//   quantized bytes. Scale bytes give no result.
//   out_valid/out_ready carry out_value_bits (float32 of scale * q) and
//   out_last_in_block on the final element of a block.
// Result: each accepted element byte is converted and stored in the output register.
// Throughput: one byte per cycle when not stalled, set by the single output
//   register which refills in the cycle it is drained.
// Reset: byte position and scale clear to zero; output register empties.
// Stall: while out_valid is high and out_ready low, in_ready drops and
//   the held result stays unchanged.
`default_nettype none
module q8_0_block_dequantizer_unit import q8d_pkg::*; #(
  parameter int BLOCK_ELEMENTS = BLOCK_ELEMENTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_stream_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_value_bits,
  output logic             out_last_in_block
);
  logic take, is_elem, is_last;
  logic [15:0] scale;
  logic valid_r;
  logic [31:0] val_r;
  logic last_r;
  assign in_ready = !valid_r || out_ready;
  assign take = in_valid && in_ready;
  q8d_ctrl #(.BLOCK_ELEMENTS(BLOCK_ELEMENTS)) u_ctrl (
    .clk, .rst_n, .take, .byte_in(in_stream_byte),
    .is_elem, .is_last, .scale
  );
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= take && is_elem;
    end
    if (take && is_elem) begin
      val_r <= scale_value(scale, in_stream_byte);
      last_r <= is_last;
    end
  end
  assign out_valid = valid_r;
  assign out_value_bits = val_r;
  assign out_last_in_block = last_r;
endmodule
`default_nettype wire

[src/q8d_checker.sv]
// Port-level checker for the dequantizer, bound to the top level.
`default_nettype none
module q8d_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_value_bits,
  input wire logic        out_last_in_block
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value_bits) &&
    $stable(out_last_in_block))
    else $error("held result changed");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("ready low with empty output");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready) else $error("accepted while stalled");
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready) && (out_ready || !out_valid) |=> !out_valid)
    else $error("result without request");
endmodule
bind q8_0_block_dequantizer_unit q8d_checker u_chk (.*);
`default_nettype wire

[sim/tb_top.sv]
// Testbench for the Q8_0 block dequantizer: directed and random byte streams checked per result.
`timescale 1ns / 1ps
module tb_top;
  localparam int BLK_N = 32;
  localparam int STALL_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_stream_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_value_bits;
  logic        out_last_in_block;

  typedef struct packed {
    logic [31:0] value_bits;
    logic        last;
  } deq_result_t;

  deq_result_t expected_values[$];
  logic [5:0]  model_pos = '0;
  logic [15:0] model_scale = '0;
  int          err_count = 0;
  int          bytes_sent = 0;
  int          results_seen = 0;
  int          idle_cycles = 0;
  bit          rx_hold = 1'b0;
  bit          rx_no_idle = 1'b0;
  bit          tx_no_idle = 1'b0;

  q8_0_block_dequantizer_unit #(.BLOCK_ELEMENTS(BLK_N)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_stream_byte(in_stream_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_value_bits(out_value_bits), .out_last_in_block(out_last_in_block)
  );

  always #2 clk = ~clk;

  function automatic logic [31:0] half_times_byte(logic [15:0] h, logic [7:0] q);
    logic        sgn;
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [8:0]  mag;
    logic [17:0] prod;
    int          msb;
    ex = h[14:10];
    man = h[9:0];
    mag = q[7] ? (9'd256 - {1'b0, q}) : {1'b0, q};
    sgn = h[15] ^ q[7];
    if (ex == 5'd31) begin
      if (man != 0) return {h[15], 8'hFF, 1'b1, man[8:0], 13'd0};
      if (mag == 0) return 32'hFFC00000;
      return {sgn, 8'hFF, 23'd0};
    end
    prod = ((ex == 0) ? {8'd0, man} : {7'd0, 1'b1, man}) * mag;
    if (prod == 0) return {sgn, 31'd0};
    msb = 0;
    for (int i = 0; i < 18; i++) if (prod[i]) msb = i;
    return {sgn, 8'(msb + ((ex == 0) ? 1 : ex) + 102), 23'((prod << (23 - msb)))};
  endfunction

  task automatic predict_byte(logic [7:0] b);
    if (model_pos == 0) begin
      model_scale[7:0] = b;
      model_pos = 1;
    end else if (model_pos == 1) begin
      model_scale[15:8] = b;
      model_pos = 2;
    end else begin
      expected_values.push_back({half_times_byte(model_scale, b), model_pos == BLK_N + 1});
      model_pos = (model_pos == BLK_N + 1) ? 6'd0 : model_pos + 6'd1;
    end
  endtask

  task automatic send_byte(logic [7:0] b);
    while (!tx_no_idle && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_stream_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_block(logic [15:0] scale, bit rnd, logic [7:0] fill);
    send_byte(scale[7:0]);
    send_byte(scale[15:8]);
    for (int i = 0; i < BLK_N; i++) send_byte(rnd ? 8'($urandom) : fill);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_values.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic test_directed();
    logic [7:0] qs [8] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'h81, 8'hFF, 8'h55, 8'hAA};
    logic [15:0] scale_set [10] = '{16'h3C00, 16'hBC00, 16'h0001, 16'h83FF, 16'h7BFF,
                                    16'h7C00, 16'hFC00, 16'h7E01, 16'hFD55, 16'h0000};
    foreach (scale_set[k]) begin
      send_byte(scale_set[k][7:0]);
      send_byte(scale_set[k][15:8]);
      for (int i = 0; i < BLK_N; i++) send_byte(qs[i % 8]);
    end
  endtask

  task automatic test_random_blocks();
    logic [15:0] s;
    for (int n = 0; n < 6; n++) begin
      case ($urandom_range(3))
        0: s = {1'($urandom_range(1)), 5'd31, 10'($urandom)};
        1: s = {1'($urandom_range(1)), 5'd0, 10'($urandom)};
        default: s = 16'($urandom);
      endcase
      if (n == 2) tx_no_idle = 1'b1;
      if (n == 5) tx_no_idle = 1'b0;
      send_block(s, 1'b1, 8'h00);
    end
  endtask

  task automatic test_backpressure();
    rx_hold = 1'b1;
    fork
      begin
        repeat (200) @(negedge clk);
        rx_hold = 1'b0;
      end
      send_block(16'($urandom), 1'b1, 8'h00);
    join
    wait_drained();
    rx_no_idle = 1'b1;
    tx_no_idle = 1'b1;
    send_block(16'h4000, 1'b1, 8'h00);
    rx_no_idle = 1'b0;
    tx_no_idle = 1'b0;
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (rst_n) out_ready <= !rx_hold && (rx_no_idle || $urandom_range(99) >= 31);
  end

  always @(posedge clk) begin
    deq_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_values.size() == 0) begin
        $display("%0t: unexpected result value=%h last=%b", $time, out_value_bits,
                 out_last_in_block);
        err_count++;
      end else begin
        exp_r = expected_values.pop_front();
        if (exp_r.value_bits !== out_value_bits) begin
          $display("%0t: value mismatch expected %h actual %h", $time, exp_r.value_bits,
                   out_value_bits);
          err_count++;
        end
        if (exp_r.last !== out_last_in_block) begin
          $display("%0t: last flag mismatch expected %b actual %b", $time, exp_r.last,
                   out_last_in_block);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random_blocks();
    wait_drained();
    repeat (10) @(negedge clk);
    $display("Sent %0d bytes, checked %0d values incl. subnormal, inf and NaN scales",
             bytes_sent, results_seen);
    if (err_count == 0 && expected_values.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
